// File: rtl/core/nptxt_pkg.sv
`default_nettype none

package nptxt_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned STEP_W = 3;

    // values above this overflow when multiplied by 100
    localparam logic [63:0] SCALE_MAX = 64'd184467440737095516;
    localparam logic [63:0] SCALED_LIMIT = 64'd99950;
    localparam logic [63:0] FRACTION_LIMIT = 64'd995;
    localparam logic [STEP_W-1:0] STEP_MAX = 3'd6;

    localparam int unsigned IEC_SHIFT = 10;
    localparam int unsigned SI_DIVISOR = 1000;

    // long division by 1000, 16 bits of the dividend per chunk
    localparam int unsigned DIV_CHUNK_W = 16;
    localparam int unsigned DIV_CHUNKS = VALUE_W / DIV_CHUNK_W;
    localparam int unsigned DIV_REM_W = 10;
    localparam int unsigned DIV_X_W = DIV_REM_W + DIV_CHUNK_W;
    localparam int unsigned RECIP_SHIFT = 36;
    localparam logic [26:0] RECIP_1000 = 27'd68719476;

    // reciprocals for rounding and digit split
    localparam logic [7:0] RECIP_10 = 8'd205;
    localparam int unsigned RECIP_10_SHIFT = 11;
    localparam logic [17:0] RECIP_100 = 18'd167773;
    localparam int unsigned RECIP_100_SHIFT = 24;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_DOT = 8'h2E;
    localparam logic [7:0] ASCII_I = 8'h69;

    localparam logic [7:0] SI_LETTERS [0:6] =
        '{8'h2D, 8'h6B, 8'h4D, 8'h47, 8'h54, 8'h50, 8'h45};
    localparam logic [7:0] IEC_LETTERS [0:6] =
        '{8'h2D, 8'h4B, 8'h4D, 8'h47, 8'h54, 8'h50, 8'h45};

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL100,
        OP_SHIFT,
        OP_DIV_INIT,
        OP_DIV_MUL,
        OP_DIV_FIX,
        OP_ROUND,
        OP_DIG1,
        OP_DIG2,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic si;
        logic big;
        logic ge_limit;
    } dp_status_t;

    function automatic logic [7:0] prefix_letter(input logic si, input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] s;
        s = (step > STEP_MAX) ? STEP_MAX : step;
        return si ? SI_LETTERS[s] : IEC_LETTERS[s];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/number_to_prefixed_decimal_text_core.sv
// the prefix step counts every division, a prescaling one before the x100 included
// throughput: one item at a time; a decimal division is a 4-chunk long division, each
//   chunk a multiply step and a fix step, a binary division is one shift per cycle
// done is high for one cycle and the receiver cannot stall; busy falls in that same cycle
// reset clears the controller, the done strobe and si_mode (binary prefixes)
`default_nettype none

module number_to_prefixed_decimal_text_core
    import nptxt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    output logic                    done,
    output logic [7:0]              char_first,
    output logic [7:0]              char_second,
    output logic [7:0]              char_third,
    output logic [7:0]              char_fourth,
    output logic [7:0]              char_fifth,
    output logic [2:0]              text_length
);

    dp_cmd_t    cmd;
    dp_status_t status;

    nptxt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    nptxt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .value       (value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .char_first  (char_first),
        .char_second (char_second),
        .char_third  (char_third),
        .char_fourth (char_fourth),
        .char_fifth  (char_fifth),
        .text_length (text_length)
    );

endmodule

`default_nettype wire

// File: rtl/core/nptxt_ctrl.sv
`default_nettype none

module nptxt_ctrl
    import nptxt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_TEST,
        S_DMUL,
        S_DFIX,
        S_DIG1,
        S_DIG2,
        S_EMIT
    } state_t;

    localparam int unsigned CHUNK_CNT_W = $clog2(DIV_CHUNKS);

    state_t                 state_reg, state_next;
    logic [CHUNK_CNT_W-1:0] chunk_reg, chunk_next;
    logic                   pre_reg, pre_next;
    logic                   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        chunk_next = chunk_reg;
        pre_next   = pre_reg;
        cmd.op     = OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.big)
                begin
                    // prescale by the divisor before the multiply
                    if (status.si)
                    begin
                        cmd.op     = OP_DIV_INIT;
                        chunk_next = '0;
                        pre_next   = 1'b1;
                        state_next = S_DMUL;
                    end
                    else
                    begin
                        cmd.op     = OP_SHIFT;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    cmd.op     = OP_MUL100;
                    state_next = S_TEST;
                end
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL100;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (status.ge_limit)
                begin
                    if (status.si)
                    begin
                        cmd.op     = OP_DIV_INIT;
                        chunk_next = '0;
                        state_next = S_DMUL;
                    end
                    else
                    begin
                        cmd.op = OP_SHIFT;
                    end
                end
                else
                begin
                    cmd.op     = OP_ROUND;
                    state_next = S_DIG1;
                end
            end
            S_DMUL:
            begin
                cmd.op     = OP_DIV_MUL;
                state_next = S_DFIX;
            end
            S_DFIX:
            begin
                cmd.op     = OP_DIV_FIX;
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == CHUNK_CNT_W'(DIV_CHUNKS - 1))
                begin
                    chunk_next = '0;
                    if (pre_reg)
                    begin
                        pre_next   = 1'b0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_TEST;
                    end
                end
                else
                begin
                    state_next = S_DMUL;
                end
            end
            S_DIG1:
            begin
                cmd.op     = OP_DIG1;
                state_next = S_DIG2;
            end
            S_DIG2:
            begin
                cmd.op     = OP_DIG2;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.op     = OP_EMIT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chunk_reg <= '0;
            pre_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
            pre_reg   <= pre_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// File: rtl/core/nptxt_datapath.sv
`default_nettype none

module nptxt_datapath
    import nptxt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              status,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    output logic                    done,
    output logic [7:0]              char_first,
    output logic [7:0]              char_second,
    output logic [7:0]              char_third,
    output logic [7:0]              char_fourth,
    output logic [7:0]              char_fifth,
    output logic [2:0]              text_length
);

    logic                 si_mode_reg;
    logic                 done_reg, done_next;

    logic [VALUE_W-1:0]   v_reg, v_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIV_REM_W-1:0] rem_reg, rem_next;
    logic [DIV_X_W-1:0]   x_reg, x_next;
    logic [15:0]          qest_reg, qest_next;
    logic [9:0]           b_reg, b_next;
    logic                 frac_reg, frac_next;
    logic [6:0]           q1_reg, q1_next;
    logic [3:0]           ones_reg, ones_next;
    logic [3:0]           hund_reg, hund_next;
    logic [7:0]           text_reg [5];
    logic [7:0]           text_next [5];
    logic [2:0]           len_reg, len_next;

    // arithmetic
    logic [VALUE_W-1:0]   mul100;
    logic [DIV_X_W-1:0]   div_x;
    logic [52:0]          div_prod;
    logic [DIV_X_W-1:0]   div_sub;
    logic [10:0]          div_r;
    logic                 div_fix;
    logic [10:0]          div_r_fix;
    logic [15:0]          div_q_fix;
    logic                 round_frac;
    logic [16:0]          round_x;
    logic [34:0]          round_prod;
    logic [9:0]           round_b;
    logic [17:0]          dig1_prod;
    logic [9:0]           ones_wide;
    logic [14:0]          hund_prod;
    logic [6:0]           tens_wide;
    logic [3:0]           tens;
    logic [2:0]           n;
    logic [7:0]           letter;

    assign status.si       = si_mode_reg;
    assign status.big      = (v_reg > SCALE_MAX);
    assign status.ge_limit = (v_reg >= SCALED_LIMIT);

    assign mul100 = (v_reg << 6) + (v_reg << 5) + (v_reg << 2);

    // one 16-bit chunk of the long division by 1000
    assign div_x     = {rem_reg, v_reg[VALUE_W-1 -: DIV_CHUNK_W]};
    assign div_prod  = 53'(div_x) * 53'(RECIP_1000);
    assign div_sub   = x_reg - DIV_X_W'(qest_reg) * DIV_X_W'(SI_DIVISOR);
    assign div_r     = div_sub[10:0];
    assign div_fix   = (div_r >= 11'(SI_DIVISOR));
    assign div_q_fix = div_fix ? qest_reg + 16'd1 : qest_reg;
    assign div_r_fix = div_fix ? div_r - 11'(SI_DIVISOR) : div_r;

    // rounding: tenths when a prefix applies and the value is small, else units
    assign round_frac = (step_reg != '0) && (v_reg < FRACTION_LIMIT);
    assign round_x    = v_reg[16:0] + (round_frac ? 17'd5 : 17'd50);
    assign round_prod = 35'(round_x) * (round_frac ? 35'(RECIP_10) : 35'(RECIP_100));
    assign round_b    = round_frac ? round_prod[RECIP_10_SHIFT +: 10]
                                   : round_prod[RECIP_100_SHIFT +: 10];

    assign dig1_prod = 18'(b_reg) * 18'(RECIP_10);
    assign ones_wide = b_reg - 10'(q1_reg) * 10'd10;
    assign hund_prod = 15'(q1_reg) * 15'(RECIP_10);
    assign tens_wide = q1_reg - 7'(hund_reg) * 7'd10;
    assign tens      = tens_wide[3:0];
    assign letter    = prefix_letter(si_mode_reg, step_reg);

    always_comb
    begin
        v_next    = v_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        x_next    = x_reg;
        qest_next = qest_reg;
        b_next    = b_reg;
        frac_next = frac_reg;
        q1_next   = q1_reg;
        ones_next = ones_reg;
        hund_next = hund_reg;
        for (int k = 0; k < 5; k++)
        begin
            text_next[k] = text_reg[k];
        end
        len_next  = len_reg;
        done_next = 1'b0;
        n         = 3'd1;
        case (cmd.op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                v_next    = value;
                step_next = '0;
            end
            OP_MUL100:
            begin
                v_next = mul100;
            end
            OP_SHIFT:
            begin
                v_next    = v_reg >> IEC_SHIFT;
                step_next = step_reg + 1'b1;
            end
            OP_DIV_INIT:
            begin
                rem_next  = '0;
                step_next = step_reg + 1'b1;
            end
            OP_DIV_MUL:
            begin
                x_next    = div_x;
                qest_next = div_prod[RECIP_SHIFT +: 16];
            end
            OP_DIV_FIX:
            begin
                // quotient bits shift in from the bottom as the dividend leaves the top
                v_next   = {v_reg[VALUE_W-DIV_CHUNK_W-1:0], div_q_fix};
                rem_next = div_r_fix[DIV_REM_W-1:0];
            end
            OP_ROUND:
            begin
                b_next    = round_b;
                frac_next = round_frac;
            end
            OP_DIG1:
            begin
                q1_next = dig1_prod[RECIP_10_SHIFT +: 7];
            end
            OP_DIG2:
            begin
                ones_next = ones_wide[3:0];
                hund_next = hund_prod[RECIP_10_SHIFT +: 4];
            end
            OP_EMIT:
            begin
                for (int k = 0; k < 5; k++)
                begin
                    text_next[k] = 8'h00;
                end
                if (frac_reg)
                begin
                    text_next[0] = ASCII_ZERO + {4'h0, tens};
                    text_next[1] = ASCII_DOT;
                    text_next[2] = ASCII_ZERO + {4'h0, ones_reg};
                    n            = 3'd3;
                end
                else if (hund_reg != 4'd0)
                begin
                    text_next[0] = ASCII_ZERO + {4'h0, hund_reg};
                    text_next[1] = ASCII_ZERO + {4'h0, tens};
                    text_next[2] = ASCII_ZERO + {4'h0, ones_reg};
                    n            = 3'd3;
                end
                else if (tens != 4'd0)
                begin
                    text_next[0] = ASCII_ZERO + {4'h0, tens};
                    text_next[1] = ASCII_ZERO + {4'h0, ones_reg};
                    n            = 3'd2;
                end
                else
                begin
                    text_next[0] = ASCII_ZERO + {4'h0, ones_reg};
                    n            = 3'd1;
                end
                len_next = n;
                if (step_reg != '0)
                begin
                    for (int k = 0; k < 5; k++)
                    begin
                        if (3'(k) == n)
                        begin
                            text_next[k] = letter;
                        end
                        else if (!si_mode_reg && (3'(k) == n + 3'd1))
                        begin
                            text_next[k] = ASCII_I;
                        end
                    end
                    len_next = n + (si_mode_reg ? 3'd1 : 3'd2);
                end
                done_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            si_mode_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                si_mode_reg <= cfg_wr_data;
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        step_reg <= step_next;
        rem_reg  <= rem_next;
        x_reg    <= x_next;
        qest_reg <= qest_next;
        b_reg    <= b_next;
        frac_reg <= frac_next;
        q1_reg   <= q1_next;
        ones_reg <= ones_next;
        hund_reg <= hund_next;
        for (int k = 0; k < 5; k++)
        begin
            text_reg[k] <= text_next[k];
        end
        len_reg  <= len_next;
    end

    assign done        = done_reg;
    assign char_first  = text_reg[0];
    assign char_second = text_reg[1];
    assign char_third  = text_reg[2];
    assign char_fourth = text_reg[3];
    assign char_fifth  = text_reg[4];
    assign text_length = len_reg;

endmodule

`default_nettype wire
